// ----- src/ipfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipfd_pkg
// Shared constants, types and the CORDIC arctangent table for the I/Q polar
// FM discriminator.
// ----------------------------------------------------------------------------
package ipfd_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // fixed formats
  localparam int GUARD      = 8;
  localparam int TABLE_LEN  = 24;
  localparam int RATE_BITS  = 24;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [23:0] INV_GAIN = 24'd10188014;
  localparam logic [RATE_BITS-1:0] SAMPLE_RATE_RST = 24'd48000;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_RATE = 1'b0;

  localparam logic [31:0] HALF_CIRCLE = 32'h8000_0000;

  // control bits carried alongside each sample through the chain
  typedef struct packed {
    logic valid;
    logic zero;
  } cell_ctl_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ----- src/ipfd_iq_if.sv -----
// ----------------------------------------------------------------------------
// ipfd_iq_if
// Valid/ready channel carrying one complex I/Q sample.
// ----------------------------------------------------------------------------
interface ipfd_iq_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_phase;
  logic signed [15:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

// ----- src/ipfd_fm_if.sv -----
// ----------------------------------------------------------------------------
// ipfd_fm_if
// Valid/ready channel carrying magnitude, frequency and phase of one sample.
// ----------------------------------------------------------------------------
interface ipfd_fm_if;
  logic               valid;
  logic               ready;
  logic        [15:0] magnitude;
  logic signed [23:0] inst_frequency;
  logic        [15:0] phase_angle;

  modport source (output valid, output magnitude, output inst_frequency,
                  output phase_angle, input ready);
  modport sink   (input valid, input magnitude, input inst_frequency,
                  input phase_angle, output ready);
endinterface

// ----- src/iq_polar_fm_discriminator.sv -----
// ----------------------------------------------------------------------------
// iq_polar_fm_discriminator
// Complex I/Q sample to magnitude, binary-angle phase and instantaneous
// frequency, through a pipelined CORDIC and a phase-step discriminator.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                   handshake
//  samples   in         in_phase[15:0], quadrature[15:0]          valid/ready
//  results   out        magnitude, inst_frequency, phase_angle    valid/ready
//  apb       in/out     sample_rate at byte address 0             psel/penable
//
//  One sample enters per clock while the chain is not stalled. A result
//  passes through the pre-rotation stage (loaded at the edge that takes its
//  sample), one register per CORDIC cell, the multiply stage and the
//  output register before it is offered.
//  A stalled result freezes the whole chain, so samples is ready exactly
//  when the output register is empty or being drained.
//  Reset clears all valid flags, the stored phase and loads sample_rate
//  with 48000.
// ----------------------------------------------------------------------------
module iq_polar_fm_discriminator import ipfd_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int PHASE_BITS    = PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  // streams
  ipfd_iq_if.sink              samples,
  ipfd_fm_if.source            results
);

  // datapath width: guard bits, one bit for the half-circle negation and
  // one for CORDIC growth (about 1.65 times root two at worst)
  localparam int W = SAMPLE_BITS + GUARD + 2;

  logic                  en;
  logic [RATE_BITS-1:0]  sample_rate;

  // --- configuration -------------------------------------------------------
  // word decoded on paddr[2]; the low byte-offset bits are ignored
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SAMPLE_RATE)) begin
      sample_rate <= pwdata[RATE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SAMPLE_RATE) begin
      prdata = DATA_BITS'(sample_rate);
    end
  end

  // --- flow control --------------------------------------------------------
  // the chain moves whenever the output register can take a new value
  assign en            = !results.valid || results.ready;
  assign samples.ready = en;

  // --- pre-rotation --------------------------------------------------------
  // low SAMPLE_BITS of each field, sign-extended, scaled by the guard bits;
  // a sample in the left half-plane is turned by half a circle first
  logic signed [SAMPLE_BITS-1:0] x_s;
  logic signed [SAMPLE_BITS-1:0] y_s;
  logic signed [W-1:0]           x_g;
  logic signed [W-1:0]           y_g;
  logic signed [W-1:0]           x_pre_next;
  logic signed [W-1:0]           y_pre_next;
  logic        [31:0]            z_pre_next;
  cell_ctl_t                     ctl_pre_next;

  always_comb begin
    x_s = SAMPLE_BITS'({16'b0, samples.in_phase});
    y_s = SAMPLE_BITS'({16'b0, samples.quadrature});
    x_g = W'(x_s) <<< GUARD;
    y_g = W'(y_s) <<< GUARD;
    ctl_pre_next.valid = samples.valid;
    ctl_pre_next.zero  = (x_s == '0) && (y_s == '0);
    if (x_g < 0) begin
      x_pre_next = -x_g;
      y_pre_next = -y_g;
      z_pre_next = HALF_CIRCLE;
    end else begin
      x_pre_next = x_g;
      y_pre_next = y_g;
      z_pre_next = '0;
    end
  end

  // chain taps: index 0 is the pre-rotation register, k+1 is cell k
  cell_ctl_t           ctl_c [CORDIC_STAGES+1];
  logic signed [W-1:0] x_c   [CORDIC_STAGES+1];
  logic signed [W-1:0] y_c   [CORDIC_STAGES+1];
  logic        [31:0]  z_c   [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0] <= '0;
    end else if (en) begin
      ctl_c[0] <= ctl_pre_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_c[0] <= x_pre_next;
      y_c[0] <= y_pre_next;
      z_c[0] <= z_pre_next;
    end
  end

  // --- CORDIC chain --------------------------------------------------------
  // each cell rotates towards the x axis by atan(2^-k) and hands on
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    ipfd_cordic_cell #(
      .W   (W),
      .IDX (k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (ctl_c[k]),
      .x_in   (x_c[k]),
      .y_in   (y_c[k]),
      .z_in   (z_c[k]),
      .ctl    (ctl_c[k+1]),
      .x      (x_c[k+1]),
      .y      (y_c[k+1]),
      .z      (z_c[k+1])
    );
  end

  // --- discriminator and output register -----------------------------------
  // y of the last cell is near zero and not needed further
  ipfd_post #(
    .W          (W),
    .PHASE_BITS (PHASE_BITS)
  ) u_post (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .ctl_in         (ctl_c[CORDIC_STAGES]),
    .x_in           (x_c[CORDIC_STAGES]),
    .z_in           (z_c[CORDIC_STAGES]),
    .sample_rate    (sample_rate),
    .valid          (results.valid),
    .magnitude      (results.magnitude),
    .inst_frequency (results.inst_frequency),
    .phase_angle    (results.phase_angle)
  );

endmodule

// ----- src/ipfd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// ipfd_cordic_cell
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module ipfd_cordic_cell import ipfd_pkg::*; #(
  parameter int          W   = SAMPLE_BITS_DEF + GUARD + 2,
  parameter int unsigned IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cell_ctl_t           ctl_in,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic        [31:0]  z_in,
  output cell_ctl_t           ctl,
  output logic signed [W-1:0] x,
  output logic signed [W-1:0] y,
  output logic        [31:0]  z
);

  localparam logic [31:0] ANGLE = atan_entry(IDX);

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  logic        [31:0]  z_next;

  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (!y_in[W-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ANGLE;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

// ----- src/ipfd_post.sv -----
// ----------------------------------------------------------------------------
// ipfd_post
// Phase rounding, phase step and the two scaling multiplies, then the
// output register with magnitude rounding and saturation.
// ----------------------------------------------------------------------------
module ipfd_post import ipfd_pkg::*; #(
  parameter int W          = SAMPLE_BITS_DEF + GUARD + 2,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  cell_ctl_t             ctl_in,
  input  logic signed [W-1:0]   x_in,
  input  logic        [31:0]    z_in,
  input  logic [RATE_BITS-1:0]  sample_rate,
  output logic                  valid,
  output logic        [15:0]    magnitude,
  output logic signed [23:0]    inst_frequency,
  output logic        [15:0]    phase_angle
);

  localparam int MAG_W  = W + 24;
  localparam int FREQ_W = PHASE_BITS + RATE_BITS + 1;
  localparam int MAG_SH = 24 + GUARD;
  localparam int MSH_W  = MAG_W + 1 - MAG_SH;
  localparam logic [31:0] Z_ROUND = 32'(64'd1 << (31 - PHASE_BITS));
  localparam logic [MAG_W:0] M_ROUND = (MAG_W+1)'(64'd1 << (23 + GUARD));

  logic [PHASE_BITS-1:0]   last_phase;
  logic [31:0]             z_rnd;
  logic [PHASE_BITS-1:0]   phase_next;
  logic [PHASE_BITS-1:0]   dp;
  logic [MAG_W-1:0]        mag_prod_next;
  logic signed [FREQ_W-1:0] freq_prod_next;

  logic                    valid_a;
  logic [PHASE_BITS-1:0]   phase_a;
  logic [MAG_W-1:0]        mag_prod;
  logic signed [FREQ_W-1:0] freq_prod;

  logic [MAG_W:0]          mag_sum;
  logic [MSH_W-1:0]        mag_sh;
  logic signed [FREQ_W-1:0] freq_sh;

  // stage A: round the angle, take the step, multiply
  always_comb begin
    z_rnd      = z_in + Z_ROUND;
    phase_next = ctl_in.zero ? '0 : z_rnd[31 -: PHASE_BITS];
    dp         = phase_next - last_phase;   // wraps modulo the full circle
    mag_prod_next  = ctl_in.zero ? '0 :
                     MAG_W'($unsigned(x_in)) * MAG_W'(INV_GAIN);
    freq_prod_next = signed'(dp) * signed'({1'b0, sample_rate});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a    <= 1'b0;
      last_phase <= '0;
    end else if (en) begin
      valid_a <= ctl_in.valid;
      if (ctl_in.valid) begin
        last_phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_a   <= phase_next;
      mag_prod  <= mag_prod_next;
      freq_prod <= freq_prod_next;
    end
  end

  // stage B: round and saturate magnitude, floor-shift frequency
  always_comb begin
    mag_sum = {1'b0, mag_prod} + M_ROUND;
    mag_sh  = mag_sum[MAG_W -: MSH_W];
    freq_sh = freq_prod >>> PHASE_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magnitude      <= (mag_sh > MSH_W'(17'h0FFFF)) && (MSH_W > 16) ? 16'hFFFF
                                                                      : 16'(mag_sh);
      inst_frequency <= freq_sh[23:0];
      phase_angle    <= 16'(phase_a);
    end
  end

endmodule
